FILE: hdl/shc_pkg.sv
// Package for the symmetric hypercube address generator.
// Holds field widths, arithmetic constants and the sideband type shared by the design modules.
// Depends on nothing.
`default_nettype none

package shc_pkg;

  // Field widths fixed by the interface.
  localparam int COORD_W = 12;
  localparam int AXIS_W  = 13;
  localparam int NUM_W   = 36;
  localparam int OFS_W   = 8;

  // Internal arithmetic widths.
  // QW: minicube coordinate, HW: q(q+1)/2, XW: q(q+1)(q+2)/2, CW: q(q+1)(q+2)/6.
  localparam int QW = COORD_W - 2;
  localparam int HW = 2 * QW;
  localparam int XW = 29;
  localparam int CW = 28;

  // Multiplicative inverse of three modulo 2**CW, for exact division by three.
  localparam logic [CW-1:0] INV3 = 28'hAAAAAAB;

  // Reset value of the axis length register and the default channel limit.
  localparam int AXIS_RESET   = 4096;
  localparam int MAX_CHANNELS = 4096;

  // Cycles from an accepted transaction to its result strobe.
  localparam int LATENCY = 7;

  typedef logic [COORD_W-1:0] coord_t;

  // Control and status that travel alongside the data through the pipeline.
  typedef struct packed {
    logic             valid;
    logic             range_err;
    logic [OFS_W-1:0] offset;
  } shc_side_t;

endpackage : shc_pkg

`default_nettype wire

FILE: hdl/shc_sort.sv
// Two-stage sorting network for the four channel coordinates, with the range check.
// Depends on shc_pkg for the coordinate type and the sideband struct.
`default_nettype none

module shc_sort import shc_pkg::*; #(
  parameter int LIM_W = AXIS_W
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  input  wire coord_t           coord_a_i,
  input  wire coord_t           coord_b_i,
  input  wire coord_t           coord_c_i,
  input  wire coord_t           coord_d_i,
  input  wire logic [LIM_W-1:0] limit_i,
  output coord_t                sorted_o [4],
  output shc_side_t             side_o
);

  coord_t    l1     [4];
  coord_t    a_d    [4];
  coord_t    a_q    [4];
  logic      err_d;
  logic      a_err_q;
  logic      a_valid_q;
  coord_t    b_d    [4];
  coord_t    b_q    [4];
  shc_side_t side_d;
  shc_side_t side_q;

  // First two layers of the network and the range compare.
  always_comb begin
    l1[0] = (coord_a_i > coord_b_i) ? coord_b_i : coord_a_i;
    l1[1] = (coord_a_i > coord_b_i) ? coord_a_i : coord_b_i;
    l1[2] = (coord_c_i > coord_d_i) ? coord_d_i : coord_c_i;
    l1[3] = (coord_c_i > coord_d_i) ? coord_c_i : coord_d_i;
    a_d[0] = (l1[0] > l1[2]) ? l1[2] : l1[0];
    a_d[2] = (l1[0] > l1[2]) ? l1[0] : l1[2];
    a_d[1] = (l1[1] > l1[3]) ? l1[3] : l1[1];
    a_d[3] = (l1[1] > l1[3]) ? l1[1] : l1[3];
    err_d = (LIM_W'(coord_a_i) >= limit_i) || (LIM_W'(coord_b_i) >= limit_i) ||
            (LIM_W'(coord_c_i) >= limit_i) || (LIM_W'(coord_d_i) >= limit_i);
  end

  // Final layer orders the middle pair; the cell offset is taken from the sorted values.
  always_comb begin
    b_d[0] = a_q[0];
    b_d[3] = a_q[3];
    b_d[1] = (a_q[1] > a_q[2]) ? a_q[2] : a_q[1];
    b_d[2] = (a_q[1] > a_q[2]) ? a_q[1] : a_q[2];
    side_d.valid     = a_valid_q;
    side_d.range_err = a_err_q;
    side_d.offset    = {b_d[3][1:0], b_d[2][1:0], b_d[1][1:0], b_d[0][1:0]};
  end

  // Stage valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      side_q    <= '0;
    end else begin
      a_valid_q <= in_valid_i;
      side_q    <= side_d;
    end
  end

  // Stage payload.
  always_ff @(posedge clk_i) begin
    a_q     <= a_d;
    a_err_q <= err_d;
    b_q     <= b_d;
  end

  assign sorted_o = b_q;
  assign side_o   = side_q;

  // The network must leave the four values in ascending order.
  a_sorted_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    side_q.valid |-> (b_q[0] <= b_q[1]) && (b_q[1] <= b_q[2]) && (b_q[2] <= b_q[3]))
    else $error("sorted coordinates out of order");

endmodule : shc_sort

`default_nettype wire

FILE: hdl/shc_arith.sv
// Five-stage arithmetic pipeline for the packed minicube number of a sorted point.
// Depends on shc_pkg for widths, the inverse of three and the sideband struct.
`default_nettype none

module shc_arith import shc_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire coord_t     sorted_i [4],
  input  wire shc_side_t  side_i,
  output logic [NUM_W-1:0] minicube_number_o,
  output logic [OFS_W-1:0] cell_offset_o,
  output logic             range_error_o,
  output logic             done_o
);

  logic [QW-1:0]   q0;
  logic [QW-1:0]   q1;
  logic [QW-1:0]   q2;
  logic [QW-1:0]   q3;
  logic [QW:0]     q1p1;
  logic [QW:0]     q2p1;
  logic [QW:0]     q3p1;
  logic [2*QW:0]   m1;
  logic [2*QW:0]   m2;
  logic [2*QW:0]   m3;

  // Stage 1: q values and the triangular numbers q(q+1)/2.
  logic [QW-1:0]   q0_q;
  logic [HW-1:0]   h1_q;
  logic [HW-1:0]   h2_q;
  logic [HW-1:0]   h3_q;
  logic [QW:0]     q2p2_q;
  logic [QW:0]     q3p2_q;
  logic [QW:0]     q3p3_s1_q;

  // Stage 2: products q(q+1)(q+2)/2.
  logic [HW+QW:0]  x2_d;
  logic [HW+QW:0]  x3_d;
  logic [XW-1:0]   x2_q;
  logic [XW-1:0]   x3_q;
  logic [HW:0]     s01_q;
  logic [QW:0]     q3p3_s2_q;

  // Stage 3: exact division by three.
  logic [CW-1:0]   c2_q;
  logic [CW-1:0]   c3_q;
  logic [HW:0]     s01_s3_q;
  logic [QW:0]     q3p3_s3_q;

  // Stage 4: fourth binomial term before the final shift.
  logic [CW+QW:0]  p3_q;
  logic [CW:0]     s012_q;

  // Stage 5: output register.
  logic [NUM_W-1:0] num_q;

  shc_side_t       side_q [5];

  // Triangular numbers from the sorted coordinates.
  always_comb begin
    q0   = sorted_i[0][COORD_W-1:2];
    q1   = sorted_i[1][COORD_W-1:2];
    q2   = sorted_i[2][COORD_W-1:2];
    q3   = sorted_i[3][COORD_W-1:2];
    q1p1 = {1'b0, q1} + (QW+1)'(1);
    q2p1 = {1'b0, q2} + (QW+1)'(1);
    q3p1 = {1'b0, q3} + (QW+1)'(1);
    m1   = q1 * q1p1;
    m2   = q2 * q2p1;
    m3   = q3 * q3p1;
  end

  // Multiply by q+2 to reach the tetrahedral numerator.
  always_comb begin
    x2_d = h2_q * q2p2_q;
    x3_d = h3_q * q3p2_q;
  end

  // Sideband shift line, cleared by reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 5; i++) begin
        side_q[i] <= '0;
      end
    end else begin
      side_q[0] <= side_i;
      for (int i = 1; i < 5; i++) begin
        side_q[i] <= side_q[i-1];
      end
    end
  end

  // Arithmetic stages.
  always_ff @(posedge clk_i) begin
    q0_q      <= q0;
    h1_q      <= m1[HW:1];
    h2_q      <= m2[HW:1];
    h3_q      <= m3[HW:1];
    q2p2_q    <= {1'b0, q2} + (QW+1)'(2);
    q3p2_q    <= {1'b0, q3} + (QW+1)'(2);
    q3p3_s1_q <= {1'b0, q3} + (QW+1)'(3);

    x2_q      <= x2_d[XW-1:0];
    x3_q      <= x3_d[XW-1:0];
    s01_q     <= (HW+1)'(q0_q) + (HW+1)'(h1_q);
    q3p3_s2_q <= q3p3_s1_q;

    c2_q      <= x2_q[CW-1:0] * INV3;
    c3_q      <= x3_q[CW-1:0] * INV3;
    s01_s3_q  <= s01_q;
    q3p3_s3_q <= q3p3_s2_q;

    p3_q      <= c3_q * q3p3_s3_q;
    s012_q    <= (CW+1)'(s01_s3_q) + (CW+1)'(c2_q);

    num_q     <= NUM_W'(s012_q) + p3_q[NUM_W+1:2];
  end

  assign minicube_number_o = num_q;
  assign cell_offset_o     = side_q[4].offset;
  assign range_error_o     = side_q[4].range_err;
  assign done_o            = side_q[4].valid;

  // The numerators are multiples of three, so the quotients must multiply back exactly.
  a_div3_exact_c2: assert property (@(posedge clk_i) disable iff (!rst_ni)
    side_q[2].valid |-> ((XW+1)'(c2_q) * (XW+1)'(3)) == (XW+1)'($past(x2_q)))
    else $error("inexact division by three on the third term");

  a_div3_exact_c3: assert property (@(posedge clk_i) disable iff (!rst_ni)
    side_q[2].valid |-> ((XW+1)'(c3_q) * (XW+1)'(3)) == (XW+1)'($past(x3_q)))
    else $error("inexact division by three on the fourth term");

endmodule : shc_arith

`default_nettype wire

FILE: hdl/symmetric_hypercube_address.sv
// Address generator for a fully symmetric 4-D histogram. It accepts one coordinate
// transaction per clock and never raises busy. Each result appears on the result ports for
// one cycle with done_o high, once its start has passed through the sorting network and then
// the multiply-and-add pipeline, at most one multiplier deep per stage.
// Results come out in order and the receiver cannot hold them off, so it must take every
// result in the cycle that done_o marks. axis_length is clipped to MAX_CHANNELS when written
// and may be changed only while no transaction is in flight.
// Depends on shc_pkg, shc_sort and shc_arith.
`default_nettype none

module symmetric_hypercube_address import shc_pkg::*; #(
  parameter int MAX_CHANNELS = shc_pkg::MAX_CHANNELS
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output logic                   busy,
  input  wire coord_t            coord_a_i,
  input  wire coord_t            coord_b_i,
  input  wire coord_t            coord_c_i,
  input  wire coord_t            coord_d_i,
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic [AXIS_W-1:0] cfg_data_i,
  output logic                   done_o,
  output logic [NUM_W-1:0]       minicube_number_o,
  output logic [OFS_W-1:0]       cell_offset_o,
  output logic                   range_error_o
);

  localparam int MaxW  = $clog2(MAX_CHANNELS + 1);
  localparam int LimW  = (MaxW > AXIS_W) ? MaxW : AXIS_W;
  localparam int LimRst = (AXIS_RESET < MAX_CHANNELS) ? AXIS_RESET : MAX_CHANNELS;

  logic [LimW-1:0] limit_d;
  logic [LimW-1:0] limit_q;
  logic            accept;
  coord_t          sorted [4];
  shc_side_t       side;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start && !busy;

  // Effective axis length: the written value, clipped to the channel limit.
  always_comb begin
    if (LimW'(cfg_data_i) < LimW'(MAX_CHANNELS)) begin
      limit_d = LimW'(cfg_data_i);
    end else begin
      limit_d = LimW'(MAX_CHANNELS);
    end
  end

  // Axis length register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LimW'(LimRst);
    end else if (cfg_valid_i && cfg_ready_o) begin
      limit_q <= limit_d;
    end
  end

  shc_sort #(
    .LIM_W (LimW)
  ) u_sort (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (accept),
    .coord_a_i  (coord_a_i),
    .coord_b_i  (coord_b_i),
    .coord_c_i  (coord_c_i),
    .coord_d_i  (coord_d_i),
    .limit_i    (limit_q),
    .sorted_o   (sorted),
    .side_o     (side)
  );

  shc_arith u_arith (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .sorted_i          (sorted),
    .side_i            (side),
    .minicube_number_o (minicube_number_o),
    .cell_offset_o     (cell_offset_o),
    .range_error_o     (range_error_o),
    .done_o            (done_o)
  );

  // A result strobe only ever follows an accepted transaction by the fixed latency.
  a_done_follows_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept, LATENCY))
    else $error("result strobe without a matching transaction");

endmodule : symmetric_hypercube_address

`default_nettype wire

FILE: dv/symmetric_hypercube_address_tb.sv
// Self-checking testbench for symmetric_hypercube_address: random and directed coordinate tuples
// are checked against a sorting and packed-index predictor, over several axis lengths.
// Depends on shc_pkg and the symmetric_hypercube_address RTL.
`timescale 1ns / 100ps

module symmetric_hypercube_address_tb;
  import shc_pkg::*;

  localparam int CLK_HALF     = 2;
  localparam int RESET_CYCLES = 6;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int MAX_REPORTS  = 10;
  localparam int COORD_MAX    = (1 << COORD_W) - 1;
  localparam int NUM_PHASES   = 8;

  // One packed address as the block should deliver it.
  typedef struct {
    logic [NUM_W-1:0] number;
    logic [OFS_W-1:0] offset;
    logic             range_err;
  } cube_addr_t;

  // Predicts the address of each accepted tuple and checks results in order.
  class cube_address_board;
    cube_addr_t        pending_q[$];
    logic [AXIS_W-1:0] axis_len;
    int                failures;

    function new();
      axis_len = AXIS_W'(AXIS_RESET);
      failures = 0;
    endfunction

    function void set_axis(logic [AXIS_W-1:0] value);
      axis_len = value;
    endfunction

    function int channel_limit();
      return (axis_len < AXIS_W'(MAX_CHANNELS)) ? int'(axis_len) : MAX_CHANNELS;
    endfunction

    function void report(string msg);
      if (failures < MAX_REPORTS) begin
        $display("[%0t] %s", $time, msg);
      end
      failures++;
    endfunction

    // Sorts the tuple with a five-comparator network and forms the packed index.
    function void note_coords(coord_t a, coord_t b, coord_t c, coord_t d);
      coord_t     s[4];
      coord_t     t;
      logic [63:0] q[4];
      logic [63:0] sum;
      int         lo_idx[5] = '{0, 2, 0, 1, 1};
      int         hi_idx[5] = '{1, 3, 2, 3, 2};
      cube_addr_t e;
      s[0] = a;
      s[1] = b;
      s[2] = c;
      s[3] = d;
      e.range_err = 1'b0;
      for (int i = 0; i < 4; i++) begin
        if (int'(s[i]) >= channel_limit()) e.range_err = 1'b1;
      end
      for (int k = 0; k < 5; k++) begin
        if (s[lo_idx[k]] > s[hi_idx[k]]) begin
          t = s[lo_idx[k]];
          s[lo_idx[k]] = s[hi_idx[k]];
          s[hi_idx[k]] = t;
        end
      end
      for (int i = 0; i < 4; i++) q[i] = 64'(s[i] >> 2);
      sum = q[0] + (q[1] * (q[1] + 1)) / 2
          + (q[2] * (q[2] + 1) * (q[2] + 2)) / 6
          + (q[3] * (q[3] + 1) * (q[3] + 2) * (q[3] + 3)) / 24;
      e.number = sum[NUM_W-1:0];
      e.offset = {s[3][1:0], s[2][1:0], s[1][1:0], s[0][1:0]};
      pending_q.push_back(e);
    endfunction

    function void check_result(logic [NUM_W-1:0] number, logic [OFS_W-1:0] offset,
                               logic range_err);
      cube_addr_t e;
      if (pending_q.size() == 0) begin
        report($sformatf("Unexpected result: number %0d offset %02h range_error %b",
                         number, offset, range_err));
        return;
      end
      e = pending_q.pop_front();
      if (number !== e.number)
        report($sformatf("minicube_number mismatch: expected %0d, got %0d", e.number, number));
      if (offset !== e.offset)
        report($sformatf("cell_offset mismatch: expected %02h, got %02h", e.offset, offset));
      if (range_err !== e.range_err)
        report($sformatf("range_error mismatch: expected %b, got %b", e.range_err, range_err));
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              start;
  logic              busy;
  coord_t            coord_a_i;
  coord_t            coord_b_i;
  coord_t            coord_c_i;
  coord_t            coord_d_i;
  logic              cfg_valid_i;
  logic              cfg_ready_o;
  logic [AXIS_W-1:0] cfg_data_i;
  logic              done_o;
  logic [NUM_W-1:0]  minicube_number_o;
  logic [OFS_W-1:0]  cell_offset_o;
  logic              range_error_o;

  cube_address_board board = new();
  int                cycle_count = 0;

  symmetric_hypercube_address uut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start             (start),
    .busy              (busy),
    .coord_a_i         (coord_a_i),
    .coord_b_i         (coord_b_i),
    .coord_c_i         (coord_c_i),
    .coord_d_i         (coord_d_i),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_data_i        (cfg_data_i),
    .done_o            (done_o),
    .minicube_number_o (minicube_number_o),
    .cell_offset_o     (cell_offset_o),
    .range_error_o     (range_error_o)
  );

  // Free-running clock.
  always begin
    clk_i = 1'b1;
    #CLK_HALF;
    clk_i = 1'b0;
    #CLK_HALF;
  end

  // Watchdog: ends the run as failed once the cycle count reaches CYCLE_LIMIT.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Monitor: checks each result strobe, then records each accepted transaction.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) board.check_result(minicube_number_o, cell_offset_o, range_error_o);
      if (start && !busy) board.note_coords(coord_a_i, coord_b_i, coord_c_i, coord_d_i);
    end
  end

  // Presents one tuple and holds it until the block takes it; returns at a falling edge.
  task automatic drive_item(coord_t a, coord_t b, coord_t c, coord_t d);
    start     <= 1'b1;
    coord_a_i <= a;
    coord_b_i <= b;
    coord_c_i <= c;
    coord_d_i <= d;
    do @(posedge clk_i); while (busy);
    @(negedge clk_i);
  endtask

  task automatic rest(int cycles);
    start <= 1'b0;
    repeat (cycles) @(negedge clk_i);
  endtask

  // Stops sending and waits for every outstanding result.
  task automatic drain();
    rest(1);
    while (board.pending_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_axis(logic [AXIS_W-1:0] value);
    drain();
    repeat (LATENCY) @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    board.set_axis(value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Biased coordinate: full range, inside the axis, at its edge, or an extreme.
  function automatic coord_t rand_coord(int lim);
    int mode;
    int v;
    mode = $urandom_range(0, 9);
    case (mode)
      5, 6, 7: begin
        v = (lim > 0) ? $urandom_range(0, lim - 1) : 0;
      end
      8: begin
        v = lim - 1 + $urandom_range(0, 2);
        if (v < 0) v = 0;
        if (v > COORD_MAX) v = COORD_MAX;
      end
      9: begin
        v = $urandom_range(0, 1) ? COORD_MAX : 0;
      end
      default: begin
        v = $urandom_range(0, COORD_MAX);
      end
    endcase
    return coord_t'(v);
  endfunction

  // Random bursts with random gaps; ties between coordinates are forced now and then.
  task automatic random_phase(int count);
    int     sent;
    int     burst;
    int     gap;
    int     lim;
    coord_t c[4];
    sent = 0;
    lim  = board.channel_limit();
    while (sent < count) begin
      burst = $urandom_range(1, 16);
      for (int j = 0; j < burst && sent < count; j++) begin
        for (int i = 0; i < 4; i++) c[i] = rand_coord(lim);
        if ($urandom_range(0, 7) == 0) begin
          c[1] = c[0];
          if ($urandom_range(0, 1)) c[3] = c[2];
        end
        drive_item(c[0], c[1], c[2], c[3]);
        sent++;
      end
      gap = $urandom_range(0, 9);
      if (gap >= 9) begin
        rest($urandom_range(5, 12));
      end else if (gap >= 3) begin
        rest($urandom_range(1, 4));
      end
    end
  endtask

  logic [AXIS_W-1:0] phase_axis[NUM_PHASES];
  int                phase_items[NUM_PHASES];

  initial begin
    phase_axis  = '{AXIS_W'(4), AXIS_W'(0), AXIS_W'(8191), AXIS_W'(4095), AXIS_W'(1),
                    AXIS_W'(2048), AXIS_W'($urandom_range(4, 4096)), AXIS_W'(4096)};
    phase_items = '{150, 150, 250, 250, 100, 250, 250, 100};

    rst_ni      = 1'b0;
    start       = 1'b0;
    coord_a_i   = '0;
    coord_b_i   = '0;
    coord_c_i   = '0;
    coord_d_i   = '0;
    cfg_valid_i = 1'b0;
    cfg_data_i  = '0;
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed tuples at the reset axis length: extremes, orderings, ties and bit patterns.
    drive_item(12'd0, 12'd0, 12'd0, 12'd0);
    drive_item(12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF);
    drive_item(12'hFFF, 12'd0, 12'hFFF, 12'd0);
    drive_item(12'd3, 12'd2, 12'd1, 12'd0);
    drive_item(12'd0, 12'd1, 12'd2, 12'd3);
    drive_item(12'd4095, 12'd4094, 12'd4093, 12'd4092);
    drive_item(12'd16, 12'd12, 12'd8, 12'd4);
    drive_item(12'd7, 12'd7, 12'd7, 12'd7);
    drive_item(12'd1023, 12'd4095, 12'd2047, 12'd3071);
    drive_item(12'hAAA, 12'h555, 12'hFFF, 12'h000);
    drive_item(12'h555, 12'hAAA, 12'h000, 12'hFFF);
    drive_item(12'd9, 12'd5, 12'd9, 12'd5);
    rest(3);
    drive_item(12'd4095, 12'd0, 12'd0, 12'd0);
    drive_item(12'd0, 12'd0, 12'd0, 12'd4095);

    // Directed tuples on an axis length of four: either side of the range boundary.
    write_axis(AXIS_W'(4));
    drive_item(12'd3, 12'd3, 12'd3, 12'd3);
    drive_item(12'd4, 12'd0, 12'd0, 12'd0);
    drive_item(12'd0, 12'd0, 12'd0, 12'd4);
    drive_item(12'd2, 12'd0, 12'd3, 12'd1);
    drive_item(12'hFFF, 12'd1, 12'd2, 12'd3);

    // Random phases; each phase after the first writes its axis length while the block is idle.
    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p > 0) write_axis(phase_axis[p]);
      random_phase(phase_items[p]);
    end

    drain();
    repeat (LATENCY + 4) @(posedge clk_i);
    if (board.failures == 0 && board.pending_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
